// File: sv/cmsi_pkg.sv
// Package for the colormap segment interpolator: constants, outcome codes, types.
// No dependencies; used by every module of the block.
package cmsi_pkg;

   localparam int unsigned MaxEntriesDefault = 64;
   localparam int unsigned ValueWidth        = 32;
   localparam int unsigned ColorWidth        = 24;
   localparam int unsigned CountWidth        = 7;
   localparam int unsigned IndexWidth        = 6;

   typedef enum logic [2:0] {
      OUT_INTERP = 3'd0,
      OUT_BELOW  = 3'd1,
      OUT_ABOVE  = 3'd2,
      OUT_EXACT  = 3'd3,
      OUT_GAP    = 3'd4
   } outcome_type;

   typedef enum logic [2:0] {
      REG_COUNT  = 3'd0,
      REG_BG_EN  = 3'd1,
      REG_BG_COL = 3'd2,
      REG_FG_EN  = 3'd3,
      REG_FG_COL = 3'd4
   } reg_index_type;

   // Start of one division: operands handed to the divider.
   typedef struct packed {
      logic        start;
      logic [32:0] offset;   // v - start, nonnegative, below span
      logic [32:0] span;     // end - start, positive
      logic [23:0] color_s;
      logic [23:0] color_e;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [23:0] color;
   } div_rsp_type;

endpackage

// File: sv/cmsi_divider.sv
// Serial restoring divider: per channel floor(offset*(ce-cs)/span) + cs.
// Depends on cmsi_pkg. One quotient bit per cycle, three channels in turn.
module cmsi_divider
   import cmsi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   // Numerator magnitude < 2^33 * 255 < 2^41; quotient magnitude < 256.
   logic [1:0]  chan_ff, chan_in;
   logic [5:0]  bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic [40:0] num_ff, num_in;
   logic [32:0] den_ff, den_in;
   logic [41:0] rem_ff, rem_in;
   logic [40:0] quo_ff, quo_in;
   logic        neg_ff, neg_in;
   logic [32:0] off_ff, off_in;
   logic [23:0] cs_ff, cs_in, ce_ff, ce_in, res_ff, res_in;
   logic        done_ff, done_in;

   logic [7:0]  c_s, c_e;
   logic [8:0]  diff;
   logic [7:0]  mag;
   logic [40:0] prod;
   logic [41:0] trial;
   logic [41:0] rem_sh;
   logic [40:0] quo_next;
   logic [7:0]  chan_val;
   logic        last_chan;

   // Start and end color of the channel being worked on.
   always_comb begin
      unique case (chan_ff)
         2'd0: begin c_s = cs_ff[23:16]; c_e = ce_ff[23:16]; end
         2'd1: begin c_s = cs_ff[15:8];  c_e = ce_ff[15:8];  end
         default: begin c_s = cs_ff[7:0]; c_e = ce_ff[7:0]; end
      endcase
   end

   always_comb begin
      chan_in  = chan_ff;
      bit_in   = bit_ff;
      busy_in  = busy_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      neg_in   = neg_ff;
      off_in   = off_ff;
      cs_in    = cs_ff;
      ce_in    = ce_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      rem_sh   = {rem_ff[40:0], num_ff[40]};
      trial    = rem_sh - {9'd0, den_ff};
      quo_next = {quo_ff[39:0], ~trial[41]};
      chan_val = 8'd0;
      last_chan = (chan_ff == 2'd2);
      diff = 9'd0; mag = 8'd0; prod = 41'd0;
      if (req.start) begin
         busy_in = 1'b1;
         off_in  = req.offset;
         den_in  = req.span;
         cs_in   = req.color_s;
         ce_in   = req.color_e;
         chan_in = 2'd0;
         bit_in  = 6'd0;   // 0 means load phase
      end else if (busy_ff) begin
         if (bit_ff == 6'd0) begin
            // Load: product of offset and channel delta.
            diff   = {1'b0, c_e} - {1'b0, c_s};
            neg_in = diff[8];
            mag    = diff[8] ? 8'(-diff) : diff[7:0];
            prod   = {8'd0, off_ff} * {33'd0, mag};
            num_in = prod;
            rem_in = 42'd0;
            quo_in = 41'd0;
            bit_in = 6'd41;
         end else begin
            rem_in = trial[41] ? rem_sh : trial;
            quo_in = quo_next;
            num_in = {num_ff[39:0], 1'b0};
            bit_in = bit_ff - 6'd1;
            if (bit_ff == 6'd1) begin
               // Floor: negative with remainder rounds toward minus infinity.
               if (neg_ff)
                  chan_val = c_s - quo_next[7:0]
                             - {7'd0, ((trial[41] ? rem_sh : trial) != 42'd0)};
               else
                  chan_val = c_s + quo_next[7:0];
               unique case (chan_ff)
                  2'd0: res_in[23:16] = chan_val;
                  2'd1: res_in[15:8]  = chan_val;
                  default: res_in[7:0] = chan_val;
               endcase
               if (last_chan) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  chan_in = chan_ff + 2'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      chan_ff <= chan_in;
      bit_ff  <= bit_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      off_ff  <= off_in;
      cs_ff   <= cs_in;
      ce_ff   <= ce_in;
      res_ff  <= res_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.color = res_ff;

endmodule

// File: sv/colormap_segment_interpolator.sv
// Top level of the colormap segment interpolator: breakpoint memory, scan, APB registers.
// Depends on cmsi_pkg and cmsi_divider.
//
// A write word (mode 0) stores one breakpoint (Q16.16 value and RGB color) in a
// single-port synchronous memory. A lookup word (mode 1) reads the first and
// last breakpoints, then walks the table one breakpoint per cycle, pairing
// slots 0/1, 2/3 and so on, through the memory's one read port. A match starts
// a serial divider that works on the three channels in turn. One word is in
// flight at a time; a finished result sits in an output register and the next
// word is accepted as soon as that register is free or being emptied.
// Unwritten slots read as anything. There is no clearing pass.
module colormap_segment_interpolator
   import cmsi_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = MaxEntriesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [5:0]  req_entry_index,
   input  logic signed [31:0] req_value,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [2:0]  rsp_outcome,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned NW = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned EW = (NW > CountWidth) ? NW : CountWidth;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_FIRST = 7'b0000010,
      ST_LAST  = 7'b0000100,
      ST_SCAN  = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_DONE  = 7'b0100000,
      ST_WRITE = 7'b1000000
   } state_type;

   // Configuration registers.
   logic [CountWidth-1:0] count_ff;
   logic                  bg_en_ff, fg_en_ff;
   logic [23:0]           bg_col_ff, fg_col_ff;
   logic                  cfg_wr;
   reg_index_type         cfg_idx;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   assign cfg_idx = reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         bg_en_ff  <= 1'b0;
         bg_col_ff <= '0;
         fg_en_ff  <= 1'b0;
         fg_col_ff <= '0;
      end else if (cfg_wr) begin
         priority case (cfg_idx)
            REG_COUNT:  count_ff  <= pwdata[CountWidth-1:0];
            REG_BG_EN:  bg_en_ff  <= pwdata[0];
            REG_BG_COL: bg_col_ff <= pwdata[23:0];
            REG_FG_EN:  fg_en_ff  <= pwdata[0];
            REG_FG_COL: fg_col_ff <= pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = 32'd0;
      priority case (cfg_idx)
         REG_COUNT:  prdata = {25'd0, count_ff};
         REG_BG_EN:  prdata = {31'd0, bg_en_ff};
         REG_BG_COL: prdata = {8'd0, bg_col_ff};
         REG_FG_EN:  prdata = {31'd0, fg_en_ff};
         REG_FG_COL: prdata = {8'd0, fg_col_ff};
         default:    prdata = 32'd0;
      endcase
   end

   // Count saturated to the table depth.
   logic [EW-1:0] n_eff;
   always_comb begin
      if (EW'(count_ff) > EW'(MAX_ENTRIES)) n_eff = EW'(MAX_ENTRIES);
      else                                  n_eff = EW'(count_ff);
   end

   // Breakpoint memory: one port, registered read.
   logic [55:0]   mem [MAX_ENTRIES];
   logic          mem_we;
   logic [AW-1:0] mem_addr;
   logic [55:0]   mem_wdata, mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      mem_rdata_ff <= mem[mem_addr];
   end

   state_type            state_ff, state_in;
   logic signed [31:0]   v_ff, v_in;
   logic signed [31:0]   first_ff, first_in;
   logic [55:0]          last_ff, last_in;
   logic [EW-1:0]        ptr_ff, ptr_in;     // slot whose data arrives this cycle
   logic [55:0]          seg_s_ff, seg_s_in;
   logic [55:0]          wr_ff, wr_in;
   logic [AW-1:0]        wr_addr_ff, wr_addr_in;
   logic                 wr_ok_ff, wr_ok_in;
   logic                 out_v_ff, out_v_in;
   logic [23:0]          out_col_ff, out_col_in;
   outcome_type          out_code_ff, out_code_in;
   div_req_type          dreq;
   div_rsp_type          drsp;
   logic                 accept, out_free;
   logic signed [31:0]   rd_val;

   assign out_free  = !out_v_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign rd_val    = mem_rdata_ff[55:24];

   cmsi_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   always_comb begin
      state_in    = state_ff;
      v_in        = v_ff;
      first_in    = first_ff;
      last_in     = last_ff;
      ptr_in      = ptr_ff;
      seg_s_in    = seg_s_ff;
      wr_in       = wr_ff;
      wr_addr_in  = wr_addr_ff;
      wr_ok_in    = wr_ok_ff;
      out_v_in    = out_v_ff && !rsp_ready;
      out_col_in  = out_col_ff;
      out_code_in = out_code_ff;
      mem_we      = 1'b0;
      mem_addr    = '0;
      mem_wdata   = wr_ff;
      dreq        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               v_in = req_value;
               if (!req_mode) begin
                  wr_in      = {req_value, req_red_in, req_green_in, req_blue_in};
                  wr_addr_in = AW'(req_entry_index);
                  wr_ok_in   = {26'd0, req_entry_index} < 32'(MAX_ENTRIES);
                  state_in   = ST_WRITE;
               end else if (n_eff < EW'(2)) begin
                  out_v_in    = 1'b1;
                  out_col_in  = '0;
                  out_code_in = OUT_GAP;
               end else begin
                  mem_addr = '0;
                  state_in = ST_FIRST;
               end
            end
         end
         ST_WRITE: begin
            mem_we   = wr_ok_ff;
            mem_addr = wr_addr_ff;
            state_in = ST_IDLE;
         end
         ST_FIRST: begin
            first_in = rd_val;
            mem_addr = AW'(n_eff - EW'(1));
            state_in = ST_LAST;
         end
         ST_LAST: begin
            last_in = mem_rdata_ff;
            if (v_ff < first_ff) begin
               out_v_in    = 1'b1;
               out_col_in  = bg_en_ff ? bg_col_ff : 24'd0;
               out_code_in = OUT_BELOW;
               state_in    = ST_IDLE;
            end else if (v_ff > rd_val) begin
               out_v_in    = 1'b1;
               out_col_in  = fg_en_ff ? fg_col_ff : 24'd0;
               out_code_in = OUT_ABOVE;
               state_in    = ST_IDLE;
            end else begin
               mem_addr = '0;
               ptr_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Data for slot ptr_ff is arriving; issue read of the next slot.
            mem_addr = AW'(ptr_ff + EW'(1));
            ptr_in   = ptr_ff + EW'(1);
            if (!ptr_ff[0]) begin
               seg_s_in = mem_rdata_ff;
               if (ptr_ff + EW'(1) >= n_eff) begin
                  // Unpaired last slot or end of table: no segment matched.
                  out_v_in = 1'b1;
                  if (v_ff == $signed(last_ff[55:24])) begin
                     out_col_in  = last_ff[23:0];
                     out_code_in = OUT_EXACT;
                  end else begin
                     out_col_in  = '0;
                     out_code_in = OUT_GAP;
                  end
                  state_in = ST_IDLE;
               end
            end else begin
               if (v_ff >= $signed(seg_s_ff[55:24]) && v_ff < rd_val) begin
                  dreq.start   = 1'b1;
                  dreq.offset  = 33'({v_ff[31], v_ff} - {seg_s_ff[55], seg_s_ff[55:24]});
                  dreq.span    = 33'({rd_val[31], rd_val} - {seg_s_ff[55], seg_s_ff[55:24]});
                  dreq.color_s = seg_s_ff[23:0];
                  dreq.color_e = mem_rdata_ff[23:0];
                  state_in     = ST_DIV;
               end else if (ptr_ff + EW'(1) >= n_eff) begin
                  out_v_in = 1'b1;
                  if (v_ff == $signed(last_ff[55:24])) begin
                     out_col_in  = last_ff[23:0];
                     out_code_in = OUT_EXACT;
                  end else begin
                     out_col_in  = '0;
                     out_code_in = OUT_GAP;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIV: begin
            if (drsp.done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               out_v_in    = 1'b1;
               out_col_in  = drsp.color;
               out_code_in = OUT_INTERP;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
      end
      v_ff        <= v_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      ptr_ff      <= ptr_in;
      seg_s_ff    <= seg_s_in;
      wr_ff       <= wr_in;
      wr_addr_ff  <= wr_addr_in;
      wr_ok_ff    <= wr_ok_in;
      out_col_ff  <= out_col_in;
      out_code_ff <= out_code_in;
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_red     = out_col_ff[23:16];
   assign rsp_green   = out_col_ff[15:8];
   assign rsp_blue    = out_col_ff[7:0];
   assign rsp_outcome = out_code_ff;

   // A stalled result must not be overwritten.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_outcome) && $stable(rsp_red))
      else $error("result changed while stalled");

   // Words are only taken while the sequencer is idle.
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> state_ff == ST_IDLE)
      else $error("word accepted while busy");

   // The divider only finishes while the sequencer waits for it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      drsp.done |-> state_ff == ST_DIV)
      else $error("divider result unexpected");

endmodule

// File: verif/tb_colormap_segment_interpolator.sv
// Self-checking testbench for colormap_segment_interpolator: a breakpoint-table
// predictor in a scoreboard class, valid/ready drivers, an APB register writer.
// Depends on cmsi_pkg and the colormap_segment_interpolator RTL.
module tb_colormap_segment_interpolator
   import cmsi_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned Slots      = 64;
   // The settle wait covers the longest lookup.
   localparam int unsigned SettleWait = 260;
   localparam int unsigned HoldOff    = 1500;
   localparam int unsigned StallLimit = 6000;

   typedef struct {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      outcome_type outcome;
   } color_result_type;

   // The scoreboard keeps its own copy of the breakpoint table and of the
   // registers, predicts the color of every accepted lookup word and checks
   // the returned words in order.
   class colormap_scoreboard;
      logic signed [31:0] bp_value[Slots];
      logic [23:0]        bp_color[Slots];
      logic [6:0]         count_reg;
      logic               bg_enable;
      logic [23:0]        bg_color;
      logic               fg_enable;
      logic [23:0]        fg_color;
      color_result_type   pending_colors[$];
      int                 mismatches;

      function new();
         count_reg   = 0;
         bg_enable   = 0;
         bg_color    = 0;
         fg_enable   = 0;
         fg_color    = 0;
         mismatches  = 0;
      endfunction

      function void set_register(reg_index_type idx, logic [31:0] data);
         case (idx)
            REG_COUNT:  count_reg   = data[6:0];
            REG_BG_EN:  bg_enable   = data[0];
            REG_BG_COL: bg_color    = data[23:0];
            REG_FG_EN:  fg_enable   = data[0];
            REG_FG_COL: fg_color    = data[23:0];
            default: ;
         endcase
      endfunction

      function int unsigned used_entries();
         return (count_reg > Slots) ? Slots : count_reg;
      endfunction

      // One channel of the segment: start plus the floored share of the step.
      function logic [7:0] blend(logic [7:0] cs, logic [7:0] ce, longint off, longint span);
         longint num;
         longint q;
         num = off * (longint'(ce) - longint'(cs));
         q = num / span;
         if (num < 0 && (num % span) != 0) q = q - 1;
         return 8'(longint'(cs) + q);
      endfunction

      function color_result_type predict(logic signed [31:0] sample);
         color_result_type res;
         int unsigned n;
         longint v;
         longint s;
         longint e;
         logic [23:0] cs;
         logic [23:0] ce;
         n = used_entries();
         v = sample;
         res = '{8'd0, 8'd0, 8'd0, OUT_GAP};
         if (n < 2) return res;
         if (v < longint'(bp_value[0])) begin
            {res.red, res.green, res.blue} = bg_enable ? bg_color : 24'd0;
            res.outcome = OUT_BELOW;
            return res;
         end
         if (v > longint'(bp_value[n-1])) begin
            {res.red, res.green, res.blue} = fg_enable ? fg_color : 24'd0;
            res.outcome = OUT_ABOVE;
            return res;
         end
         for (int unsigned i = 0; i + 1 < n; i += 2) begin
            s = bp_value[i];
            e = bp_value[i+1];
            if (v >= s && v < e) begin
               cs = bp_color[i];
               ce = bp_color[i+1];
               res.red   = blend(cs[23:16], ce[23:16], v - s, e - s);
               res.green = blend(cs[15:8], ce[15:8], v - s, e - s);
               res.blue  = blend(cs[7:0], ce[7:0], v - s, e - s);
               res.outcome = OUT_INTERP;
               return res;
            end
         end
         if (v == longint'(bp_value[n-1])) begin
            {res.red, res.green, res.blue} = bp_color[n-1];
            res.outcome = OUT_EXACT;
         end
         return res;
      endfunction

      function void note_word(logic mode, logic [5:0] idx, logic signed [31:0] value,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b);
         if (!mode) begin
            bp_value[idx] = value;
            bp_color[idx] = {r, g, b};
         end else begin
            pending_colors.push_back(predict(value));
         end
      endfunction

      task report(string what);
         mismatches++;
         $display("[%0t] MISMATCH: %s", $realtime, what);
      endtask

      task check_word(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [2:0] outcome);
         color_result_type want;
         if (pending_colors.size() == 0) begin
            report($sformatf("unexpected result word %h%h%h outcome %0d", r, g, b, outcome));
            return;
         end
         want = pending_colors.pop_front();
         if (r !== want.red)
            report($sformatf("red %0d, expected %0d", r, want.red));
         if (g !== want.green)
            report($sformatf("green %0d, expected %0d", g, want.green));
         if (b !== want.blue)
            report($sformatf("blue %0d, expected %0d", b, want.blue));
         if (outcome !== want.outcome)
            report($sformatf("outcome %0d, expected %0d", outcome, want.outcome));
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_mode = 0;
   logic [5:0]  req_entry_index = 0;
   logic signed [31:0] req_value = 0;
   logic [7:0]  req_red_in = 0;
   logic [7:0]  req_green_in = 0;
   logic [7:0]  req_blue_in = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [2:0]  rsp_outcome;
   logic        psel = 0;
   logic        penable = 0;
   logic        pwrite = 0;
   logic [4:0]  paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic        pready;

   colormap_scoreboard colors = new();
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_request = 0;

   colormap_segment_interpolator dut (.*);

   always #5 clock = ~clock;

   // Receiver and watchdog. Values sampled right after the edge are the ones
   // the block saw at that edge, so a handshake is judged on them. A requested
   // hold-off is counted down here, in cycles, while the sender keeps going.
   initial begin
      int unsigned quiet;
      int unsigned hold_left;
      quiet = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            quiet++;
            if (req_valid && req_ready) quiet = 0;
            if (rsp_valid && rsp_ready) begin
               quiet = 0;
               colors.check_word(rsp_red, rsp_green, rsp_blue, rsp_outcome);
            end
            if (quiet >= StallLimit) begin
               $display("Test completed with failures");
               $finish;
            end
         end
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Offers one word. Valid stays high between back-to-back words and is only
   // lowered when a random idle cycle is taken in front of the next one or when draining.
   task send_word(logic mode, logic [5:0] idx, logic signed [31:0] value, logic [23:0] rgb);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_entry_index <= idx;
      req_value       <= value;
      {req_red_in, req_green_in, req_blue_in} <= rgb;
      do @(posedge clock); while (!req_ready);
      colors.note_word(mode, idx, value, rgb[23:16], rgb[15:8], rgb[7:0]);
   endtask

   // APB write: setup cycle, then access cycle; pready is always high.
   task write_register(reg_index_type idx, logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 5'(idx) << 2;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      colors.set_register(idx, data);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Lower valid, let every expected word come back, then let a trailing
   // write word finish before the registers are touched.
   task drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (colors.pending_colors.size() != 0) @(posedge clock);
      repeat (SettleWait) @(posedge clock);
   endtask

   // Loads slots 0..n-1 with ascending values. Zero-width steps show up now
   // and then so that empty segments and repeated breakpoints are covered.
   task load_ramp(int unsigned n);
      longint v;
      v = -longint'($urandom_range(200000));
      for (int unsigned i = 0; i < n; i++) begin
         send_word(1'b0, 6'(i), 32'(v), 24'($urandom));
         case ($urandom_range(9))
            0:       v = v;
            1:       v = v + 1;
            2:       v = v + $urandom_range(70000000);
            default: v = v + $urandom_range(300000);
         endcase
         if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
      end
   endtask

   // A sample aimed at the table: inside a segment, on a breakpoint, next to
   // one, or anywhere at all.
   function logic signed [31:0] pick_sample();
      int unsigned n;
      int unsigned k;
      longint s;
      longint e;
      n = colors.used_entries();
      if (n < 2) return $urandom;
      k = $urandom_range(n - 1);
      case ($urandom_range(9))
         0, 1: return $urandom;
         2:    return colors.bp_value[k];
         3:    return colors.bp_value[k] + 1;
         4:    return colors.bp_value[k] - 1;
         default: begin
            k = k & ~1;
            if (k + 1 >= n) return colors.bp_value[k];
            s = colors.bp_value[k];
            e = colors.bp_value[k+1];
            if (e <= s) return 32'(s);
            return 32'(s + longint'({$urandom, $urandom} % 64'(e - s)));
         end
      endcase
   endfunction

   initial begin
      int unsigned counts[6];
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every slot is written first, so no lookup ever reads an unwritten slot.
      for (int unsigned i = 0; i < Slots; i++)
         send_word(1'b0, 6'(i), 32'($urandom), 24'($urandom));

      // Directed part. An empty table and a one-entry table give the gap outcome.
      send_word(1'b1, 6'd0, 32'sh7FFF_FFFF, 24'hFFFFFF);
      drain();
      write_register(REG_COUNT, 32'd1);
      send_word(1'b1, 6'd63, 32'sh8000_0000, 24'h000000);
      drain();
      // Three entries: one segment, an odd last breakpoint that bounds the range
      // and is hit exactly, a falling channel, below and above the range with
      // and without the background and foreground colors.
      write_register(REG_COUNT, 32'd3);
      send_word(1'b0, 6'd0, 32'sh8000_0000, 24'h00FF80);
      send_word(1'b0, 6'd1, 32'sh0001_0000, 24'hFF0001);
      send_word(1'b0, 6'd2, 32'sh7FFF_FFFF, 24'h123456);
      send_word(1'b1, 6'd0, 32'sh8000_0000, 24'd0);
      send_word(1'b1, 6'd0, 32'sh0000_8000, 24'd0);
      send_word(1'b1, 6'd0, 32'sh0001_0000, 24'd0);
      send_word(1'b1, 6'd0, 32'sh7FFF_FFFF, 24'd0);
      send_word(1'b1, 6'd0, 32'sh0001_0001, 24'd0);
      send_word(1'b0, 6'd0, 32'sh0000_0000, 24'hFFFFFF);
      send_word(1'b0, 6'd2, 32'sh7FFF_FFFE, 24'hFFFFFF);
      send_word(1'b1, 6'd0, 32'sh8000_0000, 24'd0);
      send_word(1'b1, 6'd0, 32'sh7FFF_FFFF, 24'd0);
      drain();
      write_register(REG_BG_EN, 32'd1);
      write_register(REG_BG_COL, 32'hFFFF_FFFF);
      write_register(REG_FG_EN, 32'd1);
      write_register(REG_FG_COL, 32'h00A5_5A3C);
      send_word(1'b1, 6'd0, 32'sh8000_0000, 24'd0);
      send_word(1'b1, 6'd0, 32'sh7FFF_FFFF, 24'd0);
      drain();

      // Random phases: table size and colors change between phases, the
      // extremes of the count among them (a count above capacity saturates).
      counts = '{64, 2, 127, 17, 64, 33};
      for (int ph = 0; ph < 6; ph++) begin
         send_idle_pct = (ph < 2) ? 31 : (ph < 4) ? 51 : 0;
         recv_idle_pct = (ph < 2) ? 51 : (ph < 4) ? 31 : 0;
         write_register(REG_COUNT, counts[ph]);
         write_register(REG_BG_EN, ph % 2);
         write_register(REG_BG_COL, (ph == 2) ? 32'd0 : $urandom);
         write_register(REG_FG_EN, (ph / 2) % 2);
         write_register(REG_FG_COL, (ph == 3) ? 32'hFF_FFFF : $urandom);
         load_ramp(colors.used_entries());
         for (int j = 0; j < 90; j++) begin
            if (ph == 1 && j == 30) hold_request = HoldOff;
            if ($urandom_range(9) == 0)
               send_word(1'b0, 6'($urandom), $urandom, 24'($urandom));
            else
               send_word(1'b1, 6'($urandom), pick_sample(), 24'($urandom));
         end
         drain();
      end

      if (colors.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
